// ===== rtl/mandelbrot_escape_time_top_assert.svh =====
// Assertion macros for the escape-time RTL, used by met_core.
`ifndef MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MET_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define MET_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/met_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time block.
package met_pkg;

   // Fixed field widths
   localparam int unsigned C_W        = 32;
   localparam int unsigned LIMIT_W    = 16;
   localparam int unsigned THR_W      = 32;
   localparam int unsigned OUT_CNT_W  = 16;
   localparam int unsigned CSR_W      = 32;
   localparam int unsigned CSR_IDX_W  = 1;

   // z components stay below 2^33 units for any fraction width
   localparam int unsigned Z_W        = 34;
   localparam int unsigned PROD_W     = 2 * Z_W;

   // Parameter defaults
   localparam int unsigned FRAC_BITS_DEF  = 28;
   localparam int unsigned COUNT_BITS_DEF = 16;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_SQ = 1'd1;
   localparam logic [LIMIT_W-1:0]   ITER_LIMIT_RST   = 16'd256;
   localparam logic [THR_W-1:0]     THRESHOLD_SQ_RST = 32'h4000_0000;

   typedef struct packed {
      logic signed [C_W-1:0] c_re;
      logic signed [C_W-1:0] c_im;
   } met_req_type;

   typedef struct packed {
      logic [OUT_CNT_W-1:0] escape_count;
      logic                 escaped;
   } met_rsp_type;

   // top -> core
   typedef struct packed {
      logic start;
      logic take;
   } met_ctl_type;

   // core -> top
   typedef struct packed {
      logic busy;
      logic done;
   } met_sts_type;

endpackage

// ===== rtl/mandelbrot_escape_time_top.sv =====
// Mandelbrot escape-time top level: handshake, config registers, result register.
// Each iteration runs S_MRR, S_MII and S_MRI, three products through the one shared
// multiplier, then S_STEP does the escape test and z update together.
// Throughput: one point at a time; req_stall stays high until the result is handed off.
// Reset (synchronous): sequencer idle, result empty, iter_limit 256, threshold_sq 4.0.
module mandelbrot_escape_time_top import met_pkg::*; #(
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  met_req_type          req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output met_rsp_type          rsp_data,
   // config write port
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // config registers
   logic [LIMIT_W-1:0] iter_limit_ff, iter_limit_in;
   logic [THR_W-1:0]   threshold_sq_ff, threshold_sq_in;

   // result register parts the core from the downstream stall
   logic        rsp_valid_ff, rsp_valid_in;
   met_rsp_type rsp_data_ff, rsp_data_in;

   met_ctl_type ctl;
   met_sts_type sts;
   met_rsp_type core_result;
   logic        load_rsp;

   always_comb begin
      iter_limit_in   = iter_limit_ff;
      threshold_sq_in = threshold_sq_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_ITER_LIMIT:   iter_limit_in   = csr_wdata[LIMIT_W-1:0];
            CSR_THRESHOLD_SQ: threshold_sq_in = csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // new point only when the sequencer is idle
   assign req_stall = sts.busy;
   assign ctl.start = req_valid & ~req_stall;

   // hand the finished result over when the output slot is free or draining
   assign load_rsp = sts.done & (~rsp_valid_ff | ~rsp_stall);
   assign ctl.take = load_rsp;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_limit_ff   <= ITER_LIMIT_RST;
         threshold_sq_ff <= THRESHOLD_SQ_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         iter_limit_ff   <= iter_limit_in;
         threshold_sq_ff <= threshold_sq_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   met_core #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .point        (req_data),
      .iter_limit   (iter_limit_ff),
      .threshold_sq (threshold_sq_ff),
      .sts          (sts),
      .result       (core_result)
   );

endmodule

// ===== rtl/met_mul.sv =====
// Shared signed multiplier with registered product.
module met_mul import met_pkg::*; (
   input  logic                     clock,
   input  logic signed [Z_W-1:0]    op_a,
   input  logic signed [Z_W-1:0]    op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/met_core.sv =====
// Iteration sequencer: z registers, escape test and update around one multiplier.
module met_core import met_pkg::*; #(
   parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  met_ctl_type        ctl,
   input  met_req_type        point,
   input  logic [LIMIT_W-1:0] iter_limit,
   input  logic [THR_W-1:0]   threshold_sq,
   output met_sts_type        sts,
   output met_rsp_type        result
);

   localparam int unsigned CMP_W =
      ((THR_W + FRAC_BITS > PROD_W) ? (THR_W + FRAC_BITS) : PROD_W) + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MRR  = 3'd1;   // zr*zr
   localparam logic [2:0] S_MII  = 3'd2;   // zi*zi
   localparam logic [2:0] S_MRI  = 3'd3;   // zr*zi
   localparam logic [2:0] S_STEP = 3'd4;   // test and update
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   met_req_type              c_ff, c_in;
   logic signed [Z_W-1:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PROD_W-1:0] sr_ff, sr_in, si_ff, si_in;
   met_rsp_type              res_ff, res_in;

   logic signed [Z_W-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] re_diff, re_sh, im_sh;
   logic [CMP_W-1:0]         mag_sq, thr_scaled;
   logic [COUNT_BITS-1:0]    limit;
   logic [31:0]              count_wide;
   logic                     escape_hit;

   met_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   always_comb begin
      case (state_ff)
         S_MII: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         S_MRI: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
      endcase
   end

   // floor shifts: Re = (zr^2 - zi^2) >> F, Im = (2 zr zi) >> F
   assign re_diff    = sr_ff - si_ff;
   assign re_sh      = re_diff >>> FRAC_BITS;
   assign im_sh      = prod >>> (FRAC_BITS - 1);
   assign mag_sq     = CMP_W'($unsigned(sr_ff)) + CMP_W'($unsigned(si_ff));
   assign thr_scaled = CMP_W'({threshold_sq, {FRAC_BITS{1'b0}}});
   assign limit      = COUNT_BITS'(iter_limit);
   assign count_wide = 32'(count_ff);
   // z = 0 before the first update is never tested
   assign escape_hit = (count_ff != '0) && (mag_sq >= thr_scaled);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      c_in     = c_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      sr_in    = sr_ff;
      si_in    = si_ff;
      res_in   = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               c_in     = point;
               zr_in    = '0;
               zi_in    = '0;
               count_in = '0;
               state_in = S_MRR;
            end
         end
         S_MRR: state_in = S_MII;
         S_MII: begin
            sr_in    = prod;
            state_in = S_MRI;
         end
         S_MRI: begin
            si_in    = prod;
            state_in = S_STEP;
         end
         S_STEP: begin
            if (escape_hit) begin
               res_in.escape_count = count_wide[OUT_CNT_W-1:0];
               res_in.escaped      = 1'b1;
               state_in            = S_DONE;
            end else if (count_ff == limit) begin
               res_in.escape_count = count_wide[OUT_CNT_W-1:0];
               res_in.escaped      = 1'b0;
               state_in            = S_DONE;
            end else begin
               zr_in    = re_sh[Z_W-1:0] + Z_W'(c_ff.c_re);
               zi_in    = im_sh[Z_W-1:0] + Z_W'(c_ff.c_im);
               count_in = count_ff + COUNT_BITS'(1);
               state_in = S_MRR;
            end
         end
         S_DONE: begin
            if (ctl.take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff   <= c_in;
      zr_ff  <= zr_in;
      zi_ff  <= zi_in;
      sr_ff  <= sr_in;
      si_ff  <= si_in;
      res_ff <= res_in;
   end

   assign sts.busy = (state_ff != S_IDLE);
   assign sts.done = (state_ff == S_DONE);
   assign result   = res_ff;

`include "mandelbrot_escape_time_top_assert.svh"

   `MET_ASSERT_IMP(a_start_idle, clock, reset, ctl.start, state_ff == S_IDLE, "start while busy")
   `MET_ASSERT_IMP(a_count_le_limit, clock, reset, state_ff == S_STEP, count_ff <= limit, "count passed limit")
   `MET_ASSERT_NXT(a_step_exit, clock, reset, state_ff == S_STEP, state_ff == S_MRR || state_ff == S_DONE, "bad step exit")
   `MET_ASSERT_NXT(a_count_inc, clock, reset, state_ff == S_STEP && state_in == S_MRR, count_ff == $past(count_ff) + COUNT_BITS'(1), "count not advanced")

endmodule

// ===== dv/mandelbrot_escape_time_top_test.sv =====
// Self-checking testbench for the Mandelbrot escape-time block.
`timescale 1ns / 100ps

module mandelbrot_escape_time_top_test;
   import met_pkg::*;

   localparam int FRAC    = FRAC_BITS_DEF;
   localparam int Q_ONE   = 1 << FRAC;          // 1.0 in Q4.28
   localparam int MAX_TAIL = 4096;              // cap on the end-of-run wait

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   met_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   met_rsp_type          rsp_data;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ITER_LIMIT;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // predictor copy of the config registers
   logic [LIMIT_W-1:0] iter_limit_q   = ITER_LIMIT_RST;
   logic [THR_W-1:0]   threshold_sq_q = THRESHOLD_SQ_RST;

   met_rsp_type pending_escapes[$];   // expected results, oldest first
   int unsigned mismatches = 0;

   // traffic shaping
   bit          sender_idles    = 1'b0;
   bit          receiver_stalls = 1'b0;
   int unsigned burst_left      = 0;
   int unsigned stall_left      = 0;

   mandelbrot_escape_time_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Escape count for one point under the current registers. Products are
   // exact; Re and Im of z*z are floored once to FRAC bits, then c is added.
   // |z|^2 is compared exactly against the threshold at 2*FRAC bits.
   function automatic met_rsp_type escape_time_of(input met_req_type pt);
      logic signed [127:0] cr, ci, zr, zi, zr_next, thr_wide, mag_sq;
      met_rsp_type r;
      cr = 128'(pt.c_re);
      ci = 128'(pt.c_im);
      zr = '0;
      zi = '0;
      thr_wide = 128'(threshold_sq_q);
      thr_wide = thr_wide << FRAC;
      r.escape_count = iter_limit_q;   // COUNT_BITS equals the register width
      r.escaped      = 1'b0;
      for (int unsigned i = 0; i < iter_limit_q; i++) begin
         zr_next = ((zr * zr - zi * zi) >>> FRAC) + cr;
         zi      = ((2 * zr * zi) >>> FRAC) + ci;
         zr      = zr_next;
         mag_sq  = zr * zr + zi * zi;
         if (mag_sq >= thr_wide) begin
            r.escape_count = OUT_CNT_W'(i + 1);
            r.escaped      = 1'b1;
            break;
         end
      end
      return r;
   endfunction

   function automatic met_req_type pt_of(input int re, input int im);
      met_req_type pt;
      pt.c_re = re;
      pt.c_im = im;
      return pt;
   endfunction

   // Mostly points around the set, where escape counts vary; the rest
   // spread over components in [-4, 4) or over the whole 32-bit range.
   function automatic met_req_type random_point();
      met_req_type pt;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         pt.c_re = int'($urandom_range(0, 3 * Q_ONE)) - 9 * (Q_ONE / 4);
         pt.c_im = int'($urandom_range(0, 5 * (Q_ONE / 2))) - 5 * (Q_ONE / 4);
      end else if (pick < 8) begin
         pt.c_re = $signed($urandom) >>> 1;
         pt.c_im = $signed($urandom) >>> 1;
      end else begin
         pt.c_re = $urandom;
         pt.c_im = $urandom;
      end
      return pt;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatches++;
   endtask

   // One request beat; gaps between bursts when the sender idles.
   task automatic send_point(input met_req_type pt);
      int unsigned gap;
      if (burst_left == 0) begin
         if (sender_idles) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left = $urandom_range(1, 6);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= pt;
      do @(posedge clock); while (req_stall);
      pending_escapes = {pending_escapes, escape_time_of(pt)};
   endtask

   // Hold off the sender until every expected result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_escapes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ITER_LIMIT:   iter_limit_q   = value[LIMIT_W-1:0];
         CSR_THRESHOLD_SQ: threshold_sq_q = value[THR_W-1:0];
         default: ;
      endcase
   endtask

   // Receiver: stall runs of random length, on when receiver_stalls is set.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= receiver_stalls && ($urandom_range(0, 2) == 0);
         stall_left <= $urandom_range(0, 11);
      end
   end

   // Result checker: every accepted result beat against the oldest expectation.
   always @(posedge clock) begin : check_results
      met_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_escapes.size() == 0) begin
            report_mismatch($sformatf("unexpected result count=%0d escaped=%0d",
                                      rsp_data.escape_count, rsp_data.escaped));
         end else begin
            want = pending_escapes.pop_front();
            if (rsp_data.escape_count !== want.escape_count)
               report_mismatch($sformatf("escape_count %0d, expected %0d",
                                         rsp_data.escape_count, want.escape_count));
            if (rsp_data.escaped !== want.escaped)
               report_mismatch($sformatf("escaped %0b, expected %0b",
                                         rsp_data.escaped, want.escaped));
         end
      end
   end

   // Reset values: extremes of both fields, the exact-threshold hit at c = -2,
   // cycles that never escape, slow escapes and negative values for floor rounding.
   task automatic test_reset_defaults();
      sender_idles    = 1'b0;
      receiver_stalls <= 1'b0;
      send_point(pt_of(0, 0));
      send_point(pt_of(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_point(pt_of(32'h8000_0000, 32'h8000_0000));
      send_point(pt_of(32'h7FFF_FFFF, 32'h8000_0000));
      send_point(pt_of(32'h8000_0000, 0));
      send_point(pt_of(0, 32'h7FFF_FFFF));
      send_point(pt_of(-2 * Q_ONE, 0));
      send_point(pt_of(-Q_ONE, 0));
      send_point(pt_of(0, Q_ONE));
      send_point(pt_of(Q_ONE / 4, 0));
      send_point(pt_of(Q_ONE / 4 + Q_ONE / 100, 0));
      send_point(pt_of(Q_ONE, 0));
      send_point(pt_of(-3 * (Q_ONE / 4), Q_ONE / 10));
      send_point(pt_of(-1, -1));
      send_point(pt_of(-Q_ONE / 2 - 1, Q_ONE / 2 + 3));
      send_point(pt_of(3 * (Q_ONE / 10), -Q_ONE / 2));
      wait_for_results();
   endtask

   // Zero threshold escapes on the first pass; the top threshold with a
   // one-pass limit.
   task automatic test_threshold_extremes();
      sender_idles    = 1'b1;
      receiver_stalls <= 1'b1;
      write_csr(CSR_THRESHOLD_SQ, '0);
      send_point(pt_of(0, 0));
      send_point(pt_of(-1, 1));
      wait_for_results();
      write_csr(CSR_THRESHOLD_SQ, 32'hFFFF_FFFF);
      write_csr(CSR_ITER_LIMIT, 32'd1);
      send_point(pt_of(0, 0));
      send_point(pt_of(32'h8000_0000, 0));
      wait_for_results();
   endtask

   // Zero limit: no pass at all, count 0 and not escaped.
   task automatic test_zero_limit();
      write_csr(CSR_THRESHOLD_SQ, THRESHOLD_SQ_RST);
      write_csr(CSR_ITER_LIMIT, '0);
      send_point(pt_of(0, 0));
      send_point(pt_of(32'h8000_0000, 32'h7FFF_FFFF));
      wait_for_results();
   endtask

   // Junk in the upper half of a limit write is dropped.
   task automatic test_wide_limit_write();
      write_csr(CSR_ITER_LIMIT, {16'hBEEF, 16'd5});
      send_point(pt_of(Q_ONE, 0));
      send_point(pt_of(0, 0));
      wait_for_results();
   endtask

   // Largest limit: one point that never escapes runs the full count.
   task automatic test_max_limit();
      write_csr(CSR_ITER_LIMIT, 32'h0000_FFFF);
      send_point(pt_of(32'h8000_0000, 32'h8000_0000));
      send_point(pt_of(Q_ONE / 4 + Q_ONE / 100, 0));
      send_point(pt_of(0, 0));
      wait_for_results();
   endtask

   task automatic test_random_points(input int unsigned count, input logic [15:0] lim,
                                     input logic [31:0] thr, input bit idle);
      write_csr(CSR_ITER_LIMIT, {16'($urandom), lim});
      write_csr(CSR_THRESHOLD_SQ, thr);
      sender_idles    = idle;
      receiver_stalls <= idle;
      repeat (count) begin
         send_point(random_point());
         if ($urandom_range(0, 49) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   initial begin : run_tests
      int unsigned tail;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_threshold_extremes();
      test_zero_limit();
      test_wide_limit_write();
      test_max_limit();
      test_random_points(120, 16'd24, THRESHOLD_SQ_RST, 1'b1);
      test_random_points(120, 16'($urandom_range(1, 40)), $urandom, 1'b1);
      test_random_points(120, 16'd64, 32'hFFFF_FFFF, 1'b0);
      test_random_points(120, 16'd1, $urandom, 1'b1);
      test_random_points(120, 16'($urandom_range(2, 12)),
                         $urandom_range(32'h1000_0000, 32'h7000_0000), 1'b1);

      // let any stray result beat show up before the verdict
      tail = 4 * (int'(iter_limit_q) + 1) + 8;
      if (tail > MAX_TAIL) tail = MAX_TAIL;
      repeat (tail) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin : watchdog
      #100_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
